FILE: rtl/core/i2c_rb_pkg.sv
// ----------------------------------------------------------------------------
// i2c_rb_pkg
// shared types, codes and constants of the i2c target register bank
// ----------------------------------------------------------------------------
package i2c_rb_pkg;

	// bank geometry
	localparam int BANK_DEPTH = 16;
	localparam int PTR_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// stream widths
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 1;
	localparam int CNT_W      = 16;

	// bus event codes
	typedef enum logic [1:0] {
		OP_ADDR = 2'd0,
		OP_DATA = 2'd1,
		OP_SENT = 2'd2
	} op_t;

	// write phase after an address match
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CAPTURE = 2'd1,
		PH_STORE   = 2'd2
	} phase_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} rb_cmd_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef ptr_t wrap_tab_t [256];

	// byte value reduced modulo the bank depth, built at elaboration
	function automatic wrap_tab_t build_wrap_tab();
		wrap_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = PTR_W'(i % BANK_DEPTH);
		end
		return t;
	endfunction

	localparam wrap_tab_t WRAP_TAB = build_wrap_tab();

endpackage

FILE: rtl/core/i2c_rb_ctrl.sv
// ----------------------------------------------------------------------------
// i2c_rb_ctrl
// sequencer: takes one beat, executes it, holds the result beat until taken
// ----------------------------------------------------------------------------
module i2c_rb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output i2c_rb_pkg::rb_cmd_t cmd
);

	i2c_rb_pkg::state_t state_q, state_nxt;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			i2c_rb_pkg::ST_IDLE: if (in_valid) state_nxt = i2c_rb_pkg::ST_EXEC;
			i2c_rb_pkg::ST_EXEC: if (out_free) state_nxt = i2c_rb_pkg::ST_IDLE;
			default:             state_nxt = i2c_rb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			i2c_rb_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			i2c_rb_pkg::ST_EXEC: cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2c_rb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/i2c_rb_dp.sv
// ----------------------------------------------------------------------------
// i2c_rb_dp
// datapath: bank memory, pointer, write phase, event counters, result register
// ----------------------------------------------------------------------------
module i2c_rb_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  i2c_rb_pkg::rb_cmd_t                   cmd,
	input  logic [i2c_rb_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [i2c_rb_pkg::IN_USER_W-1:0]      in_user,
	output logic [i2c_rb_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [i2c_rb_pkg::OUT_USER_W-1:0]     out_user
);

	localparam int D = i2c_rb_pkg::BANK_DEPTH;
	localparam int W = i2c_rb_pkg::PTR_W;
	localparam int C = i2c_rb_pkg::CNT_W;

	// bank storage, entries read as zero until first written
	logic [7:0] mem [D];
	logic       wr_ok_q [D];

	// captured item
	i2c_rb_pkg::op_t op_q;
	logic            dir_q;
	logic [7:0]      rxb_q;
	logic            nack_q;

	// bank read issued at capture
	logic [7:0] rd_byte_q;
	logic       rd_ok_q;

	// architectural state
	i2c_rb_pkg::ptr_t   ptr_q, ptr_nxt, ptr_inc;
	logic               last_dir_q, last_dir_nxt;
	i2c_rb_pkg::phase_t phase_q, phase_nxt;
	logic [C-1:0]       rx_cnt_q, rx_cnt_nxt;
	logic [C-1:0]       tx_cnt_q, tx_cnt_nxt;
	logic [C-1:0]       nack_cnt_q, nack_cnt_nxt;
	logic               send_nxt, mem_we;

	// result register
	logic         res_send_q;
	logic [7:0]   res_byte_q;
	logic [C-1:0] res_rx_q, res_tx_q, res_nack_q;

	assign ptr_inc = (ptr_q == W'(D - 1)) ? '0 : ptr_q + W'(1);

	always_comb begin
		ptr_nxt      = ptr_q;
		last_dir_nxt = last_dir_q;
		phase_nxt    = phase_q;
		rx_cnt_nxt   = rx_cnt_q;
		tx_cnt_nxt   = tx_cnt_q;
		nack_cnt_nxt = nack_cnt_q;
		send_nxt     = 1'b0;
		mem_we       = 1'b0;
		unique case (op_q)
			i2c_rb_pkg::OP_ADDR: begin
				rx_cnt_nxt   = rx_cnt_q + C'(1);
				last_dir_nxt = dir_q;
				if (!dir_q) begin
					phase_nxt = i2c_rb_pkg::PH_CAPTURE;
					ptr_nxt   = '0;
				end else begin
					send_nxt = 1'b1;
					ptr_nxt  = ptr_inc;
				end
			end
			i2c_rb_pkg::OP_DATA: begin
				rx_cnt_nxt = rx_cnt_q + C'(1);
				if (!last_dir_q) begin
					case (phase_q)
						i2c_rb_pkg::PH_CAPTURE: begin
							ptr_nxt   = i2c_rb_pkg::WRAP_TAB[rxb_q];
							phase_nxt = i2c_rb_pkg::PH_STORE;
						end
						i2c_rb_pkg::PH_STORE: begin
							mem_we  = 1'b1;
							ptr_nxt = ptr_inc;
						end
						default: ;
					endcase
				end
			end
			i2c_rb_pkg::OP_SENT: begin
				tx_cnt_nxt = tx_cnt_q + C'(1);
				if (!nack_q) begin
					send_nxt = 1'b1;
					ptr_nxt  = ptr_inc;
				end else begin
					nack_cnt_nxt = nack_cnt_q + C'(1);
				end
			end
			default: ;
		endcase
	end

	// payload capture and bank read at the pointer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= i2c_rb_pkg::op_t'(in_user);
			dir_q     <= in_data[0];
			rxb_q     <= in_data[8:1];
			nack_q    <= in_data[9];
			rd_byte_q <= mem[ptr_q];
			rd_ok_q   <= wr_ok_q[ptr_q];
		end
		if (cmd.commit && mem_we) mem[ptr_q] <= rxb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) wr_ok_q[i] <= 1'b0;
			ptr_q      <= '0;
			last_dir_q <= 1'b0;
			phase_q    <= i2c_rb_pkg::PH_IDLE;
			rx_cnt_q   <= '0;
			tx_cnt_q   <= '0;
			nack_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (mem_we) wr_ok_q[ptr_q] <= 1'b1;
			ptr_q      <= ptr_nxt;
			last_dir_q <= last_dir_nxt;
			phase_q    <= phase_nxt;
			rx_cnt_q   <= rx_cnt_nxt;
			tx_cnt_q   <= tx_cnt_nxt;
			nack_cnt_q <= nack_cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_send_q <= send_nxt;
			res_byte_q <= (send_nxt && rd_ok_q) ? rd_byte_q : 8'h00;
			res_rx_q   <= rx_cnt_nxt;
			res_tx_q   <= tx_cnt_nxt;
			res_nack_q <= nack_cnt_nxt;
		end
	end

	assign out_data = {res_nack_q, res_tx_q, res_rx_q, res_byte_q};
	assign out_user = res_send_q;

endmodule

FILE: rtl/core/i2c_target_register_bank.sv
// ----------------------------------------------------------------------------
// i2c_target_register_bank
// byte register bank behind an i2c target, stepped by one bus event per beat
// ----------------------------------------------------------------------------
// Each input beat is one bus event: an address match (with direction), a
// received data byte, or a transmit-done (with ack/nack). A write match clears
// the pointer and arms pointer capture; the first data byte then sets the
// pointer (modulo the bank depth) and later bytes are stored with
// auto-increment. A read match or an acknowledged transmit returns the bank
// byte at the pointer and advances it; a nacked transmit bumps the nack count.
// Every event returns exactly one result beat with the send flag, send byte
// and the three wrapping 16-bit event counters. An event is handled in two
// steps: the beat is captured and the bank read at the pointer, then the
// event executes and loads the result register; no new event is taken
// until the current one has executed. A result still waiting downstream does not
// block the next capture; only execution waits for the result register to
// drain. The bank reads as zero after reset with no clearing pass.
// ----------------------------------------------------------------------------
module i2c_target_register_bank (
	input  logic        clk,
	input  logic        arst_n,
	// input events
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // dir_read[0], rx_byte[8:1], got_nack[9], zero pad
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // send_byte[7:0], rx_events[23:8],
	                                   // tx_events[39:24], nack_events[55:40]
	output logic [0:0]  m_axis_tuser   // send_valid[0]
);

	// command bundle from the sequencer to the datapath
	i2c_rb_pkg::rb_cmd_t cmd;

	// sequencer: idle/execute, owns both handshakes
	i2c_rb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// datapath: bank, pointer, phase, counters and the result register
	i2c_rb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

FILE: rtl/core/i2c_rb_checker.sv
// ----------------------------------------------------------------------------
// i2c_rb_checker
// port-level checks of the i2c target register bank
// ----------------------------------------------------------------------------
module i2c_rb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// an accepted event keeps the input closed while it executes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready during execute");

	// no send flag means a zero send byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("send byte set without send flag");

	// a fresh result follows an execute cycle
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result without execute cycle");

endmodule

bind i2c_target_register_bank i2c_rb_checker u_i2c_rb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
